// File: rtl/chunked_body_decoder_top_assert.svh
// Assertion macros used by the chunked body decoder checker.
`ifndef CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cbd_pkg.sv
// Types, constants and helper functions for the chunked body decoder.
package cbd_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  // Result queue depth; one word may push two results.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_OK      = 2'd1,
    K_TRUNC   = 2'd2,
    K_OVF     = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_SKIP = 5'b00001,
    PH_HEX  = 5'b00010,
    PH_LINE = 5'b00100,
    PH_DATA = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last_of_run;
  } res_t;

  // Bit 4 set when the byte is a hex digit, low nibble is its value.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

  // Space, TAB, LF, VT, FF, CR.
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

// File: rtl/cbd_res_fifo.sv
// Small result queue: pushes up to two results per cycle, pops one.
module cbd_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  logic              push1,
  input  cbd_pkg::res_t     entry0,
  input  cbd_pkg::res_t     entry1,
  input  logic              pop,
  output cbd_pkg::res_t     head,
  output logic [cbd_pkg::RES_CNT_W-1:0] count
);

  cbd_pkg::res_t mem [cbd_pkg::RES_DEPTH];
  logic [cbd_pkg::RES_PTR_W-1:0] wr_ptr;
  logic [cbd_pkg::RES_PTR_W-1:0] rd_ptr;
  logic [cbd_pkg::RES_CNT_W-1:0] n_push;

  assign n_push = cbd_pkg::RES_CNT_W'(push0) + cbd_pkg::RES_CNT_W'(push1);
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= entry0;
    if (push1) mem[wr_ptr + 1'b1] <= entry1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cbd_pkg::RES_PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + n_push - cbd_pkg::RES_CNT_W'(pop);
    end
  end

endmodule

// File: rtl/chunked_body_decoder_top.sv
// Chunked transfer body decoder: top level with size parser and result queue.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-------------------------------
//   in      | in_valid  | in_stall  | in_byte, end_of_body
//   out     | out_valid | out_stall | out_byte, kind, last_of_run
//
// One input word is taken per cycle unless in_stall holds it; its state
// update is done in the accept cycle and its results (zero, one or two)
// go into a 4-entry queue. Results leave at one per cycle while out_stall
// is low, so a word that ends a body inside a chunk yields two results.
// in_stall rises when the queue has fewer than two free entries.
// rst is synchronous, active high; it empties the queue and returns the
// parser to skipping whitespace before a size.
module chunked_body_decoder_top #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_body,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last_of_run
);

  cbd_pkg::phase_t phase, phase_next;
  logic [SIZE_BITS-1:0] remaining_count, remaining_count_next;

  logic        accept;
  logic [4:0]  hexv;
  logic        is_hex;
  logic [3:0]  dig;
  logic        sp;
  logic        top_nz;
  logic [SIZE_BITS-1:0] rem_shift;
  logic [SIZE_BITS-1:0] rem_dec;

  logic           pay;
  logic           st;
  cbd_pkg::kind_t st_kind;

  cbd_pkg::res_t entry0, entry1, head;
  logic [cbd_pkg::RES_CNT_W-1:0] count;
  logic pop;

  assign accept = in_valid && !in_stall;
  assign hexv   = cbd_pkg::hex_value(in_byte);
  assign is_hex = hexv[4];
  assign dig    = hexv[3:0];
  assign sp     = cbd_pkg::is_space(in_byte);

  // A further digit would push the size past SIZE_BITS.
  assign top_nz    = remaining_count[SIZE_BITS-1 -: 4] != 4'd0;
  assign rem_shift = {remaining_count[SIZE_BITS-5:0], dig};
  assign rem_dec   = (remaining_count != '0) ? remaining_count - 1'b1 : remaining_count;

  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    pay                  = 1'b0;
    st                   = 1'b0;
    st_kind              = cbd_pkg::K_OK;
    unique case (phase)
      cbd_pkg::PH_SKIP: begin
        if (sp) begin
          st = end_of_body;
        end else if (is_hex) begin
          remaining_count_next = SIZE_BITS'(dig);
          phase_next           = cbd_pkg::PH_HEX;
          st                   = end_of_body;
          st_kind              = (dig == 4'd0) ? cbd_pkg::K_OK : cbd_pkg::K_TRUNC;
        end else begin
          // Garbage where a size belongs reads as size zero.
          st = 1'b1;
        end
      end
      cbd_pkg::PH_HEX: begin
        if (is_hex) begin
          if (top_nz) begin
            st      = 1'b1;
            st_kind = cbd_pkg::K_OVF;
          end else begin
            remaining_count_next = rem_shift;
            st                   = end_of_body;
            st_kind = (rem_shift == '0) ? cbd_pkg::K_OK : cbd_pkg::K_TRUNC;
          end
        end else if (remaining_count == '0) begin
          st = 1'b1;
        end else begin
          phase_next = (in_byte == cbd_pkg::LF_BYTE) ? cbd_pkg::PH_DATA : cbd_pkg::PH_LINE;
          st         = end_of_body;
          st_kind    = cbd_pkg::K_TRUNC;
        end
      end
      cbd_pkg::PH_LINE: begin
        if (in_byte == cbd_pkg::LF_BYTE) phase_next = cbd_pkg::PH_DATA;
        st      = end_of_body;
        st_kind = cbd_pkg::K_TRUNC;
      end
      cbd_pkg::PH_DATA: begin
        pay                  = 1'b1;
        remaining_count_next = rem_dec;
        if (rem_dec == '0) phase_next = cbd_pkg::PH_SKIP;
        st      = end_of_body;
        st_kind = (rem_dec == '0) ? cbd_pkg::K_OK : cbd_pkg::K_TRUNC;
      end
      cbd_pkg::PH_DONE: begin
        // Everything after the status is dropped.
      end
      default: begin
      end
    endcase
    if (st) phase_next = cbd_pkg::PH_DONE;
    // End of body always rearms for the next body.
    if (end_of_body) begin
      phase_next           = cbd_pkg::PH_SKIP;
      remaining_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= cbd_pkg::PH_SKIP;
      remaining_count <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      remaining_count <= remaining_count_next;
    end
  end

  // Payload goes first; a status, if any, is always the last result.
  always_comb begin
    entry0.out_byte    = pay ? in_byte : 8'd0;
    entry0.kind        = pay ? cbd_pkg::K_PAYLOAD : st_kind;
    entry0.last_of_run = !(pay && st);
    entry1.out_byte    = 8'd0;
    entry1.kind        = st_kind;
    entry1.last_of_run = 1'b1;
  end

  assign pop = out_valid && !out_stall;

  cbd_res_fifo u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .push0  (accept && (pay || st)),
    .push1  (accept && pay && st),
    .entry0 (entry0),
    .entry1 (entry1),
    .pop    (pop),
    .head   (head),
    .count  (count)
  );

  assign in_stall    = count > cbd_pkg::RES_CNT_W'(cbd_pkg::RES_DEPTH - 2);
  assign out_valid   = count != '0;
  assign out_byte    = head.out_byte;
  assign kind        = head.kind;
  assign last_of_run = head.last_of_run;

endmodule

// File: rtl/cbd_checker.sv
// Port-level checker for the chunked body decoder, bound to the top level.
`include "chunked_body_decoder_top_assert.svh"

module cbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic       last_of_run
);

  `CBD_ASSERT_NOW(a_status_last, out_valid && kind != cbd_pkg::K_PAYLOAD, last_of_run, "status word not last of run")
  `CBD_ASSERT_NOW(a_status_zero, out_valid && kind != cbd_pkg::K_PAYLOAD, out_byte == 8'd0, "status word carries nonzero byte")
  `CBD_ASSERT_NEXT(a_run_cont, out_valid && !last_of_run, out_valid, "run broken before its last word")
  `CBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(kind) && $stable(last_of_run), "stalled output word changed")

endmodule

bind chunked_body_decoder_top cbd_checker u_cbd_checker (.*);
